>>> hdl/psu_pkg.sv
`default_nettype none

package psu_pkg;

  localparam int DEF_MAX_ROW_BYTES = 8192;
  localparam int DEF_PIXEL_BYTES   = 4;

  localparam int PIX_W    = 12;
  localparam int ROW_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_PIXELS = 1'b0,
    CFG_ROW_COUNT  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filt_t;

  // paeth predictor: pa = |b-c|, pb = |a-c|, pc = |a+b-2c|
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [10:0] pa;
    logic [10:0] pb;
    logic [10:0] pc;
    logic [7:0] res;
    da = $signed({3'b000, b}) - $signed({3'b000, c});
    db = $signed({3'b000, a}) - $signed({3'b000, c});
    dc = da + db;
    pa = (da < 0) ? 11'(-da) : 11'(da);
    pb = (db < 0) ? 11'(-db) : 11'(db);
    pc = (dc < 0) ? 11'(-dc) : 11'(dc);
    if (pa <= pb && pa <= pc) begin
      res = a;
    end else if (pb <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/png_scanline_unfilter.sv
// png scanline unfilter
// in channel: one decompressed byte per item (in_valid/in_ready). the first
// byte of each row is the filter type and yields no output item; every other
// byte yields one reconstructed byte on the out channel (out_valid/out_ready)
// with row_end, image_end and bad_filter flags.
// cfg channel: cfg_index 0 writes row_pixels (cfg_data[11:0]), 1 writes
// row_count; cfg_ready is always high. write only while the block is idle.
// path: an accepted sample byte is registered in the compute stage, then in the output register, and shown on out_*.
// throughput: one byte per cycle while out_ready is high, filter bytes included. the previous row
// lives in a single-port-write, one-read synchronous ram read at accept and
// written back when the byte leaves the compute stage, so the row-to-row
// dependency never overlaps.
// reset: registers return to row_pixels 1, row_count 1, row 0, waiting for a
// filter byte; the row ram is not cleared (row 0 ignores its read data).
// stall: when out_ready is low the output register and the compute stage hold
// and in_ready drops once both are full; no item is lost or repeated.
`default_nettype none

module png_scanline_unfilter
  import psu_pkg::*;
#(
  parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
  parameter int PIXEL_BYTES   = DEF_PIXEL_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_filtered_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                out_pixel_byte,
  output logic                      out_row_end,
  output logic                      out_image_end,
  output logic                      out_bad_filter,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = $clog2(MAX_ROW_BYTES);
  localparam int NW = AW + 1;
  localparam int SW = (PIXEL_BYTES > 1) ? $clog2(PIXEL_BYTES) : 1;
  localparam int PW = PIX_W + $clog2(PIXEL_BYTES + 1);
  localparam int CW = (PW > NW) ? PW : NW;

  // configuration
  logic [PIX_W-1:0] row_pixels_r;
  logic [ROW_W-1:0] row_count_r;

  // front control state
  logic          awaiting_r, awaiting_nxt;
  filt_t         filt_r, filt_nxt;
  logic [AW-1:0] col_r, col_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // compute stage
  logic          s1_v_r, s1_v_nxt;
  logic [7:0]    s1_x_r;
  logic [AW-1:0] s1_col_r;
  logic [SW-1:0] s1_slot_r;
  logic          s1_first_r;
  logic          s1_top_r;
  logic          s1_last_col_r;
  logic          s1_img_end_r;
  filt_t         s1_filt_r;

  // output register
  logic          out_valid_r;
  logic [7:0]    out_pix_r;
  logic          out_row_end_r;
  logic          out_img_end_r;
  logic          out_bad_r;

  logic [7:0] upper_mem [MAX_ROW_BYTES];
  logic [7:0] rd_data_r;
  logic [7:0] left_hist_r [PIXEL_BYTES];
  logic [7:0] ul_hist_r [PIXEL_BYTES];

  logic             in_acc;
  logic             samp_acc;
  logic             s1_adv;
  logic [PIX_W-1:0] px_eff;
  logic [CW-1:0]    prod;
  logic [CW-1:0]    prod_cap;
  logic [NW-1:0]    row_bytes;
  logic [NW-1:0]    col_inc;
  logic             last_col;
  logic [ROW_W-1:0] rows_eff;
  logic [ROW_W:0]   row_inc;
  logic             last_row;
  logic             first_pixel;
  logic [7:0]       a_val, b_val, c_val;
  logic [8:0]       ab_sum;
  logic [7:0]       pred;
  logic [7:0]       pix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pixels_r <= PIX_W'(1);
      row_count_r  <= ROW_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ROW_PIXELS: row_pixels_r <= cfg_data[PIX_W-1:0];
        CFG_ROW_COUNT:  row_count_r  <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // row geometry for the byte at the front
  always_comb begin
    px_eff    = (row_pixels_r == '0) ? PIX_W'(1) : row_pixels_r;
    prod      = CW'(px_eff) * CW'(PIXEL_BYTES);
    prod_cap  = (prod > CW'(MAX_ROW_BYTES)) ? CW'(MAX_ROW_BYTES) : prod;
    row_bytes = prod_cap[NW-1:0];
    col_inc   = {1'b0, col_r} + NW'(1);
    last_col  = col_inc >= row_bytes;
    rows_eff  = (row_count_r == '0) ? ROW_W'(1) : row_count_r;
    row_inc   = {1'b0, row_r} + (ROW_W+1)'(1);
    last_row  = row_inc >= {1'b0, rows_eff};
    first_pixel = {1'b0, col_r} < NW'(PIXEL_BYTES);
  end

  assign s1_adv   = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign samp_acc = in_acc && !awaiting_r;

  always_comb begin
    awaiting_nxt = awaiting_r;
    filt_nxt     = filt_r;
    col_nxt      = col_r;
    slot_nxt     = slot_r;
    row_nxt      = row_r;
    s1_v_nxt     = s1_adv ? 1'b0 : s1_v_r;
    if (in_acc) begin
      if (awaiting_r) begin
        filt_nxt     = (in_filtered_byte > 8'd4) ? FILT_BAD : filt_t'(in_filtered_byte[2:0]);
        awaiting_nxt = 1'b0;
        col_nxt      = '0;
        slot_nxt     = '0;
      end else begin
        s1_v_nxt = 1'b1;
        if (last_col) begin
          col_nxt      = '0;
          slot_nxt     = '0;
          awaiting_nxt = 1'b1;
          row_nxt      = last_row ? '0 : row_inc[ROW_W-1:0];
        end else begin
          col_nxt  = col_inc[AW-1:0];
          slot_nxt = (slot_r == SW'(PIXEL_BYTES - 1)) ? '0 : slot_r + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b1;
      filt_r     <= FILT_NONE;
      col_r      <= '0;
      slot_r     <= '0;
      row_r      <= '0;
      s1_v_r     <= 1'b0;
    end else begin
      awaiting_r <= awaiting_nxt;
      filt_r     <= filt_nxt;
      col_r      <= col_nxt;
      slot_r     <= slot_nxt;
      row_r      <= row_nxt;
      s1_v_r     <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (samp_acc) begin
      s1_x_r        <= in_filtered_byte;
      s1_col_r      <= col_r;
      s1_slot_r     <= slot_r;
      s1_first_r    <= first_pixel;
      s1_top_r      <= (row_r == '0);
      s1_last_col_r <= last_col;
      s1_img_end_r  <= last_col && last_row;
      s1_filt_r     <= filt_r;
    end
  end

  // previous-row ram: read at accept, written back when the byte leaves compute
  always_ff @(posedge clk) begin
    if (samp_acc) begin
      rd_data_r <= upper_mem[col_r];
    end
    if (s1_adv) begin
      upper_mem[s1_col_r] <= pix;
    end
  end

  always_comb begin
    a_val  = s1_first_r ? 8'd0 : left_hist_r[s1_slot_r];
    b_val  = s1_top_r ? 8'd0 : rd_data_r;
    c_val  = (s1_top_r || s1_first_r) ? 8'd0 : ul_hist_r[s1_slot_r];
    ab_sum = {1'b0, a_val} + {1'b0, b_val};
    unique case (s1_filt_r)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = a_val;
      FILT_UP:    pred = b_val;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth(a_val, b_val, c_val);
      default:    pred = 8'd0;
    endcase
    pix = s1_x_r + pred;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      left_hist_r[s1_slot_r] <= pix;
      ul_hist_r[s1_slot_r]   <= b_val;
      out_pix_r              <= pix;
      out_row_end_r          <= s1_last_col_r;
      out_img_end_r          <= s1_img_end_r;
      out_bad_r              <= (s1_filt_r == FILT_BAD);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_byte = out_pix_r;
  assign out_row_end    = out_row_end_r;
  assign out_image_end  = out_img_end_r;
  assign out_bad_filter = out_bad_r;

  // a sample byte always lands in the compute stage
  a_samp_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    samp_acc |=> s1_v_r)
    else $error("accepted sample did not reach compute stage");

  // image_end is never raised without row_end being raised as well
  a_img_row: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_img_end_r) |-> s1_last_col_r)
    else $error("image end without row end");

  // a filter byte is always taken at column zero
  a_await_col: assert property (@(posedge clk) disable iff (!rst_n)
    awaiting_r |-> (col_r == '0 && slot_r == '0))
    else $error("waiting for filter byte off column zero");

  // ram read and write-back never hit the same entry in one cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (samp_acc && s1_adv) |-> (col_r != s1_col_r))
    else $error("row ram read and write collide");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SW'(PIXEL_BYTES - 1))
    else $error("pixel slot out of range");

endmodule

`default_nettype wire
